/* design/sst_pkg.sv */
package sst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W    = 2;
    localparam int ID_W     = 16;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int IN_BITS   = CMD_W + ID_W + STAMP_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + STAMP_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STAMP_W-1:0]  found_stamp;
        logic [COUNT_W-1:0]  entry_count;
    } result_t;

endpackage

/* design/sorted_subscriber_table_top.sv */
// Sorted subscriber table: up to TABLE_DEPTH (id, stamp) entries held in ascending
// stamp order in one single-port-write, one-read RAM. Insert goes ahead of equal
// stamps, delete removes the first matching id, lookup returns the stamp of the
// first matching id; one result beat per command. A command walks the table one
// entry at a time (RAM read, then evaluate and write back): an insert walks the
// entries at or above its stamp, then a head write if it lands at the head; a
// delete walks all entries; a lookup stops at its match, or walks all entries if
// the id is missing. Inserts on an empty or full table, deletes and lookups on an
// empty one and unused codes need no walk. One command is in work at a time; a
// finished result waits in the output register while the next command is accepted.
module sorted_subscriber_table_top
    import sst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // command[1:0], sub_id[17:2], stamp[49:18]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], found_stamp[33:2], entry_count[38:34]
);

    logic [CMD_W-1:0]   command;
    logic [ID_W-1:0]    sub_id;
    logic [STAMP_W-1:0] stamp;

    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    assign command = s_tdata[CMD_W-1:0];
    assign sub_id  = s_tdata[CMD_W+ID_W-1:CMD_W];
    assign stamp   = s_tdata[IN_BITS-1:CMD_W+ID_W];

    sst_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (command),
        .in_id     (sub_id),
        .in_stamp  (stamp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sst_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sst_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* design/sst_ram.sv */
module sst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/sst_seq.sv */
module sst_seq
    import sst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     in_cmd,
    input  logic [ID_W-1:0]      in_id,
    input  logic [STAMP_W-1:0]   in_stamp,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [ENTRY_W-1:0]   wr_data,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  logic [ENTRY_W-1:0]   rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_PLACE,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [STAMP_W-1:0]  fstamp_reg, fstamp_next;

    entry_t rd_entry;
    entry_t new_entry;
    logic   last_idx;
    logic   hit;

    assign rd_entry  = entry_t'(rd_data);
    assign new_entry = '{id: id_reg, stamp: stamp_reg};
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg;
    assign hit       = !found_reg && (rd_entry.id == id_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.found_stamp = fstamp_reg;
    assign res.entry_count = COUNT_W'(fill_reg);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        stamp_next  = stamp_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        fstamp_next = fstamp_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = ENTRY_W'(new_entry);
        rd_en       = 1'b0;
        rd_addr     = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_cmd;
                    id_next     = in_id;
                    stamp_next  = in_stamp;
                    found_next  = 1'b0;
                    fstamp_next = '0;
                    status_next = ST_OK;
                    case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (fill_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else if (fill_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = {in_id, in_stamp};
                                fill_next  = fill_reg + CNT_W'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(fill_reg - CNT_W'(1));
                                state_next = S_READ;
                            end
                        end
                        CMD_DELETE, CMD_LOOKUP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_MISSING;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg + IDX_W'(1);
                        if (stamp_reg <= rd_entry.stamp)
                        begin
                            // shift up, keep scanning down
                            wr_data = rd_data;
                            if (idx_reg == '0)
                            begin
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                idx_next   = idx_reg - IDX_W'(1);
                                state_next = S_READ;
                            end
                        end
                        else
                        begin
                            fill_next  = fill_reg + CNT_W'(1);
                            state_next = S_DONE;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (hit)
                        begin
                            found_next = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            // close the gap
                            wr_en   = 1'b1;
                            wr_addr = idx_reg - IDX_W'(1);
                            wr_data = rd_data;
                        end
                        if (last_idx)
                        begin
                            if (found_reg || hit)
                            begin
                                fill_next = fill_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_MISSING;
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (rd_entry.id == id_reg)
                        begin
                            fstamp_next = rd_entry.stamp;
                            state_next  = S_DONE;
                        end
                        else if (last_idx)
                        begin
                            status_next = ST_MISSING;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        stamp_reg  <= stamp_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        fstamp_reg <= fstamp_next;
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_no_write_idle_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != S_READ && state_reg != S_DONE))
        else $error("table write outside an update step");

    a_fill_change: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            ($past(state_reg) == S_IDLE || $past(state_reg) == S_EVAL
             || $past(state_reg) == S_PLACE))
        else $error("fill count moved outside an update step");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_ready) |=> state_reg == S_IDLE)
        else $error("result handoff did not release the sequencer");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && status_reg == ST_FULL) |->
            fill_reg == CNT_W'(TABLE_DEPTH))
        else $error("full status with free room");
`endif

endmodule

/* design/sst_out.sv */
module sst_out
    import sst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  result_t               res,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg, data_next;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = OUT_DATA_W'({res.entry_count, res.found_stamp, res.status});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
